[rtl/gtas_pkg.sv]
// Shared types, constants and helpers for the gain table attenuator select block.
// Used by gtas_cmp, gtas_engine and gain_table_attenuator_select; no dependencies.
`timescale 1ns / 1ps

package gtas_pkg;

  // Table geometry and gain width.
  localparam int TABLE_ENTRIES = 64;
  localparam int GAIN_BITS     = 16;
  localparam int NUM_PAGES     = 3;

  localparam int VALUE_W = 32;
  localparam int CODE_W  = 7;
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int IW1     = IDX_W + 1;
  localparam int MEM_DEPTH = NUM_PAGES * TABLE_ENTRIES;
  localparam int ADDR_W  = $clog2(MEM_DEPTH);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Item kinds.
  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_TX    = 2'd1;
  localparam logic [1:0] KIND_RX    = 2'd2;

  // Table pages.
  localparam logic [1:0] PAGE_TX  = 2'd0;
  localparam logic [1:0] PAGE_RX1 = 2'd1;
  localparam logic [1:0] PAGE_RX2 = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_APPLIED = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_STORED  = 2'd2;

  // Outcome of comparing the target value against one table gain.
  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } cmp_t;

  // Result handed from the engine to the output register.
  typedef struct packed {
    logic              idle;
    logic              valid;
    logic [1:0]        status;
    logic [CODE_W-1:0] tx;
    logic [CODE_W-1:0] rx1;
    logic [CODE_W-1:0] rx2;
  } res_t;

  // Attenuator code of a table index: index times two, kept to the code width.
  function automatic logic [CODE_W-1:0] code_of(logic [IDX_W-1:0] ix);
    logic [IDX_W+CODE_W-1:0] w;
    w = (IDX_W + CODE_W)'(ix) << 1;
    return w[CODE_W-1:0];
  endfunction

  localparam logic [CODE_W-1:0] LAST_CODE = code_of(LAST_IDX);

endpackage

[rtl/gtas_cmp.sv]
// Shared signed compare unit: target value against one sign-extended table gain.
// Depends on gtas_pkg.
`timescale 1ns / 1ps

module gtas_cmp import gtas_pkg::*; (
  input  logic signed [VALUE_W-1:0]   value,
  input  logic signed [GAIN_BITS-1:0] gain,
  output cmp_t                        result
);

  logic signed [VALUE_W-1:0] gain_x;

  assign gain_x = VALUE_W'(gain);

  assign result.lt = (value < gain_x);
  assign result.eq = (value == gain_x);
  assign result.gt = (value > gain_x);

endmodule

[rtl/gtas_engine.sv]
// Sequencer that owns the gain table memory and the attenuator code registers.
// Range checks and the binary search run as repeated probes through one gtas_cmp.
// Depends on gtas_pkg and gtas_cmp.
`timescale 1ns / 1ps

module gtas_engine import gtas_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [1:0]                kind,
  input  logic [1:0]                page,
  input  logic [5:0]                entry,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      res_take,
  output res_t                      res
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_HI_RD,
    S_HI_CK,
    S_LO_RD,
    S_LO_CK,
    S_SPLIT_RD,
    S_SPLIT_CK,
    S_PROBE_RD,
    S_PROBE_CK,
    S_DONE
  } state_t;

  localparam logic signed [VALUE_W-1:0] GAIN_MAX =
    VALUE_W'((64'sd1 <<< (GAIN_BITS - 1)) - 64'sd1);
  localparam logic signed [VALUE_W-1:0] GAIN_MIN = -GAIN_MAX - VALUE_W'(1);

  state_t                    state;
  logic [1:0]                kind_q;
  logic [1:0]                spage;
  logic signed [VALUE_W-1:0] value_q;
  logic [IW1-1:0]            lo;
  logic [IW1-1:0]            hi_p1;
  logic [IDX_W-1:0]          mid;
  logic [IDX_W-1:0]          pick;
  logic [1:0]                status;
  logic [CODE_W-1:0]         tx_code;
  logic [CODE_W-1:0]         rx1_code;
  logic [CODE_W-1:0]         rx2_code;

  logic signed [GAIN_BITS-1:0] mem [MEM_DEPTH];
  logic signed [GAIN_BITS-1:0] rdata;
  logic [ADDR_W-1:0]           raddr;
  logic [ADDR_W-1:0]           waddr;
  logic                        wen;
  logic signed [GAIN_BITS-1:0] wdata;

  logic [IW1-1:0]   span;
  logic [IW1-1:0]   mid_sum;
  logic [IDX_W-1:0] mid_c;
  logic             window;
  cmp_t             cmp;

  function automatic logic [ADDR_W-1:0] addr_of(int pg, int ix);
    return ADDR_W'(pg * TABLE_ENTRIES + ix);
  endfunction

  function automatic logic signed [GAIN_BITS-1:0] sat_gain(logic signed [VALUE_W-1:0] v);
    logic signed [VALUE_W-1:0] c;
    if (v > GAIN_MAX) begin
      c = GAIN_MAX;
    end else if (v < GAIN_MIN) begin
      c = GAIN_MIN;
    end else begin
      c = v;
    end
    return c[GAIN_BITS-1:0];
  endfunction

  // Midpoint of the live window [lo, hi_p1 - 1].
  assign window  = (lo < hi_p1);
  assign span    = hi_p1 - lo - IW1'(1);
  assign mid_sum = lo + (span >> 1);
  assign mid_c   = mid_sum[IDX_W-1:0];

  assign wen   = start && (kind == KIND_STORE) && (page <= PAGE_RX2)
                 && (32'(entry) < TABLE_ENTRIES);
  assign waddr = addr_of(int'(page), int'(entry));
  assign wdata = sat_gain(value);

  always_comb begin
    unique case (state)
      S_HI_RD:    raddr = (kind_q == KIND_TX) ? addr_of(int'(PAGE_TX), 0)
                                              : addr_of(int'(PAGE_RX2), 0);
      S_LO_RD:    raddr = (kind_q == KIND_TX) ? addr_of(int'(PAGE_TX), int'(LAST_IDX))
                                              : addr_of(int'(PAGE_RX1), int'(LAST_IDX));
      S_SPLIT_RD: raddr = addr_of(int'(PAGE_RX1), 0);
      S_PROBE_RD: raddr = addr_of(int'(spage), int'(mid_c));
      default:    raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  gtas_cmp u_cmp (
    .value  (value_q),
    .gain   (rdata),
    .result (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      status   <= ST_APPLIED;
      tx_code  <= '0;
      rx1_code <= '0;
      rx2_code <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            kind_q  <= kind;
            value_q <= value;
            if (kind == KIND_STORE) begin
              status <= ST_STORED;
              state  <= S_DONE;
            end else if (kind == KIND_TX || kind == KIND_RX) begin
              state <= S_HI_RD;
            end else begin
              status <= ST_RANGE;
              state  <= S_DONE;
            end
          end
        end
        S_HI_RD: state <= S_HI_CK;
        S_HI_CK: begin
          if (cmp.gt) begin
            status <= ST_RANGE;
            state  <= S_DONE;
          end else begin
            state <= S_LO_RD;
          end
        end
        S_LO_RD: state <= S_LO_CK;
        S_LO_CK: begin
          if (cmp.lt) begin
            status <= ST_RANGE;
            state  <= S_DONE;
          end else if (kind_q == KIND_TX) begin
            spage <= PAGE_TX;
            lo    <= '0;
            hi_p1 <= IW1'(TABLE_ENTRIES);
            pick  <= LAST_IDX;
            state <= S_PROBE_RD;
          end else begin
            state <= S_SPLIT_RD;
          end
        end
        S_SPLIT_RD: state <= S_SPLIT_CK;
        S_SPLIT_CK: begin
          // Targets above the top of level 1 are served by level 2.
          spage <= cmp.gt ? PAGE_RX2 : PAGE_RX1;
          lo    <= '0;
          hi_p1 <= IW1'(TABLE_ENTRIES);
          pick  <= LAST_IDX;
          state <= S_PROBE_RD;
        end
        S_PROBE_RD: begin
          if (window) begin
            mid   <= mid_c;
            state <= S_PROBE_CK;
          end else begin
            status <= ST_APPLIED;
            state  <= S_DONE;
            if (spage == PAGE_TX) begin
              tx_code <= code_of(pick);
            end else if (spage == PAGE_RX2) begin
              rx2_code <= code_of(pick);
              rx1_code <= '0;
            end else begin
              rx1_code <= code_of(pick);
              rx2_code <= LAST_CODE;
            end
          end
        end
        S_PROBE_CK: begin
          // An exact hit closes the window so the next probe step applies it.
          if (cmp.eq) begin
            pick <= mid;
            lo   <= hi_p1;
          end else if (cmp.lt) begin
            lo <= {1'b0, mid} + IW1'(1);
          end else begin
            pick  <= mid;
            hi_p1 <= {1'b0, mid};
          end
          state <= S_PROBE_RD;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.idle   = (state == S_IDLE);
  assign res.valid  = (state == S_DONE);
  assign res.status = status;
  assign res.tx     = tx_code;
  assign res.rx1    = rx1_code;
  assign res.rx2    = rx2_code;

  a_probe_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE_CK) |-> (({1'b0, mid} >= lo) && ({1'b0, mid} < hi_p1)))
    else $error("probe index outside the search window");

  a_rx_levels: assert property (@(posedge clk) disable iff (rst)
    (rx1_code != '0) |-> (rx2_code == LAST_CODE))
    else $error("receive level 1 in use while level 2 is not at its last code");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == S_IDLE))
    else $error("item started while the engine is busy");

endmodule

[rtl/gain_table_attenuator_select.sv]
// Top level of the gain table attenuator select block: input handshake and result register.
// Depends on gtas_pkg and gtas_engine.
//
// One input beat is either a table store (kind 0), a transmit gain request (kind 1) or a
// receive gain request (kind 2). Every beat produces exactly one result beat carrying a
// status and the three current attenuator codes. Both channels use valid and stall; a
// beat moves when valid is high and stall is low.
// A store or an unused kind goes straight to its result. A transmit request first reads the
// top and then the bottom of its range, then runs the binary search; a receive request
// also reads the top of level 1 to choose the level. An out-of-range target ends after the
// range reads. Each range read and each binary search probe is a registered read of the
// table memory followed by a compare state.
// in_stall is high while a request is in flight, so one item is worked on at a time.
// With no output stall the engine is idle again in the same cycle that out_valid rises,
// so the next beat can be accepted then.
// The result register holds a beat while out_stall is high, and the next item may be
// accepted meanwhile; its result then waits in the engine until the register frees up.
// Reset clears the attenuator codes to zero and empties the result register; the gain
// tables are not cleared and must be written before they are searched.
`timescale 1ns / 1ps

module gain_table_attenuator_select import gtas_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                kind,
  input  logic [1:0]                page,
  input  logic [5:0]                entry,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic [CODE_W-1:0]         tx_code,
  output logic [CODE_W-1:0]         rx_first_code,
  output logic [CODE_W-1:0]         rx_second_code
);

  res_t res;
  logic start;
  logic res_take;

  assign in_stall = !res.idle;
  assign start    = in_valid && !in_stall;
  assign res_take = !out_valid || !out_stall;

  gtas_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .kind     (kind),
    .page     (page),
    .entry    (entry),
    .value    (value),
    .res_take (res_take),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      status         <= res.status;
      tx_code        <= res.tx;
      rx_first_code  <= res.rx1;
      rx_second_code <= res.rx2;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> in_stall)
    else $error("input not stalled after an accepted beat");

endmodule
